// File: rtl/core/pfs_pkg.sv
// Shared types, constants and the exact-division inverse table for the SPF factorizer.
package pfs_pkg;

    localparam int DATA_W            = 16;
    localparam int EXP_W             = 4;
    localparam int VALUE_SPAN        = 1 << DATA_W;
    localparam int DEFAULT_MAX_VALUE = 65536;

    // Odd divisors below 256 reach the inverse table through bits [7:1]
    localparam int INV_ENTRIES = 128;

    typedef logic [INV_ENTRIES-1:0][DATA_W-1:0] inv_tbl_t;

    // Build inverses of odd numbers modulo 2^16 by Newton iteration
    function automatic inv_tbl_t build_inv_table();
        inv_tbl_t          tbl;
        logic [DATA_W-1:0] p;
        logic [DATA_W-1:0] x;
        for (int k = 0; k < INV_ENTRIES; k++)
        begin
            p = DATA_W'(2 * k + 1);
            x = p;
            for (int n = 0; n < 4; n++)
            begin
                x = DATA_W'(x * DATA_W'(DATA_W'(2) - DATA_W'(p * x)));
            end
            tbl[k] = x;
        end
        return tbl;
    endfunction

    localparam inv_tbl_t INV_TABLE = build_inv_table();

    // Commands from the controller to the datapath
    typedef struct packed {
        logic init_step;
        logic outer_start;
        logic outer_read;
        logic outer_next;
        logic inner_start;
        logic inner_step;
        logic accept;
        logic step;
        logic emit_err;
        logic emit_one;
        logic emit_final;
    } pfs_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic init_last;
        logic outer_done;
        logic is_prime;
        logic inner_done;
        logic val_err;
        logic val_one;
        logic p_invalid;
        logic p_is_rem;
    } pfs_status_t;

endpackage

// File: rtl/core/pfs_datapath.sv
// Datapath: factor table memory, sieve counters, factor registers and result word registers.
module pfs_datapath #(
    parameter int MAX_VALUE = pfs_pkg::DEFAULT_MAX_VALUE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfs_pkg::pfs_cmd_t             cmd,
    input  logic [pfs_pkg::DATA_W-1:0]    value,
    output pfs_pkg::pfs_status_t          status,
    output logic                          valid,
    output logic [pfs_pkg::DATA_W-1:0]    prime,
    output logic [pfs_pkg::EXP_W-1:0]     exponent,
    output logic                          last,
    output logic                          error
);

    localparam int DW          = pfs_pkg::DATA_W;
    localparam int EW          = pfs_pkg::EXP_W;
    localparam int TABLE_DEPTH = (MAX_VALUE < pfs_pkg::VALUE_SPAN) ? MAX_VALUE
                                                                   : pfs_pkg::VALUE_SPAN;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;

    // Smallest-prime-factor table
    logic [DW-1:0]     spf_mem [TABLE_DEPTH];
    logic [DW-1:0]     rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [DW-1:0]     wr_data;
    logic              wr_en;

    // Sieve counters and pending inner-loop check
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0]  sq_reg, sq_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic              pend_reg;
    logic [ADDR_W-1:0] pend_addr_reg;

    // Factorization registers
    logic [DW-1:0]     remaining_reg, remaining_next;
    logic [DW-1:0]     cur_prime_reg, cur_prime_next;
    logic [EW-1:0]     count_reg, count_next;

    // Result word registers
    logic              valid_reg, valid_next;
    logic [DW-1:0]     prime_reg, prime_next;
    logic [EW-1:0]     exponent_reg, exponent_next;
    logic              last_reg, last_next;
    logic              error_reg, error_next;

    logic [DW-1:0]     p;
    logic [DW-1:0]     inv;
    logic [2*DW-1:0]   prod;
    logic [DW-1:0]     quotient;
    logic              emit_prev;

    assign p = rd_data_reg;

    // Select read and write ports of the table
    always_comb
    begin
        if (cmd.outer_read)
        begin
            rd_addr = i_reg;
        end
        else if (cmd.inner_step)
        begin
            rd_addr = j_reg[ADDR_W-1:0];
        end
        else
        begin
            rd_addr = remaining_reg[ADDR_W-1:0];
        end

        if (cmd.init_step)
        begin
            wr_en   = 1'b1;
            wr_addr = i_reg;
            wr_data = (!i_reg[0] && (i_reg >= ADDR_W'(4))) ? DW'(2) : DW'(i_reg);
        end
        else
        begin
            wr_en   = pend_reg && (rd_data_reg == DW'(pend_addr_reg));
            wr_addr = pend_addr_reg;
            wr_data = DW'(i_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            spf_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= spf_mem[rd_addr];
    end

    // Advance sieve counters
    always_comb
    begin
        if (cmd.outer_start)
        begin
            i_next  = ADDR_W'(3);
            sq_next = CNT_W'(9);
        end
        else if (cmd.outer_next)
        begin
            i_next  = i_reg + 1'b1;
            sq_next = sq_reg + {i_reg, 1'b1};
        end
        else if (cmd.init_step)
        begin
            i_next  = i_reg + 1'b1;
            sq_next = sq_reg;
        end
        else
        begin
            i_next  = i_reg;
            sq_next = sq_reg;
        end

        if (cmd.inner_start)
        begin
            j_next = sq_reg;
        end
        else if (cmd.inner_step)
        begin
            j_next = j_reg + CNT_W'(i_reg);
        end
        else
        begin
            j_next = j_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg    <= '0;
            sq_reg   <= '0;
            j_reg    <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            i_reg    <= i_next;
            sq_reg   <= sq_next;
            j_reg    <= j_next;
            pend_reg <= cmd.inner_step;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= j_reg[ADDR_W-1:0];
    end

    // Divide exactly by the table prime: one when it equals the remainder, shift for two, inverse multiply for odd
    assign inv  = pfs_pkg::INV_TABLE[p[7:1]];
    assign prod = remaining_reg * inv;

    always_comb
    begin
        if (p == remaining_reg)
        begin
            quotient = DW'(1);
        end
        else if (p == DW'(2))
        begin
            quotient = remaining_reg >> 1;
        end
        else
        begin
            quotient = prod[DW-1:0];
        end
    end

    // Merge runs of equal primes
    assign emit_prev = cmd.step && (p != cur_prime_reg) && (cur_prime_reg != '0);

    always_comb
    begin
        remaining_next = remaining_reg;
        cur_prime_next = cur_prime_reg;
        count_next     = count_reg;
        if (cmd.accept)
        begin
            remaining_next = value;
            cur_prime_next = '0;
            count_next     = '0;
        end
        else if (cmd.step)
        begin
            remaining_next = quotient;
            if (p == cur_prime_reg)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                cur_prime_next = p;
                count_next     = EW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            cur_prime_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            cur_prime_reg <= cur_prime_next;
            count_reg     <= count_next;
        end
    end

    // Load the result word
    always_comb
    begin
        valid_next    = 1'b0;
        prime_next    = prime_reg;
        exponent_next = exponent_reg;
        last_next     = last_reg;
        error_next    = error_reg;
        if (cmd.emit_err || cmd.emit_one)
        begin
            valid_next    = 1'b1;
            prime_next    = '0;
            exponent_next = '0;
            last_next     = 1'b1;
            error_next    = cmd.emit_err;
        end
        else if (cmd.emit_final || emit_prev)
        begin
            valid_next    = 1'b1;
            prime_next    = cur_prime_reg;
            exponent_next = count_reg;
            last_next     = cmd.emit_final;
            error_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prime_reg    <= prime_next;
        exponent_reg <= exponent_next;
        last_reg     <= last_next;
        error_reg    <= error_next;
    end

    assign valid    = valid_reg;
    assign prime    = prime_reg;
    assign exponent = exponent_reg;
    assign last     = last_reg;
    assign error    = error_reg;

    // Report status
    always_comb
    begin
        status.init_last  = (i_reg == ADDR_W'(TABLE_DEPTH - 1));
        status.outer_done = (sq_reg >= CNT_W'(TABLE_DEPTH));
        status.is_prime   = (rd_data_reg == DW'(i_reg));
        status.inner_done = (j_reg >= CNT_W'(TABLE_DEPTH));
        status.val_err    = (value == '0) ||
                            ((DW+1)'(value) >= (DW+1)'(TABLE_DEPTH));
        status.val_one    = (value == DW'(1));
        status.p_invalid  = (p < DW'(2));
        status.p_is_rem   = (p == remaining_reg);
    end

endmodule

// File: rtl/core/pfs_ctrl.sv
// Controller: sequences the sieve fill after reset and the lookup loop for each value.
module pfs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  pfs_pkg::pfs_status_t status,
    output pfs_pkg::pfs_cmd_t    cmd,
    output logic                 busy
);

    localparam logic [2:0] S_INIT      = 3'd0;
    localparam logic [2:0] S_OUTER_RD  = 3'd1;
    localparam logic [2:0] S_OUTER_CHK = 3'd2;
    localparam logic [2:0] S_INNER     = 3'd3;
    localparam logic [2:0] S_IDLE      = 3'd4;
    localparam logic [2:0] S_LOOKUP    = 3'd5;
    localparam logic [2:0] S_STEP      = 3'd6;
    localparam logic [2:0] S_FINAL     = 3'd7;

    logic [2:0] state_reg, state_next;

    // Decode state into commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (status.init_last)
                begin
                    cmd.outer_start = 1'b1;
                    state_next      = S_OUTER_RD;
                end
            end
            S_OUTER_RD:
            begin
                if (status.outer_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.outer_read = 1'b1;
                    state_next     = S_OUTER_CHK;
                end
            end
            S_OUTER_CHK:
            begin
                if (status.is_prime)
                begin
                    cmd.inner_start = 1'b1;
                    state_next      = S_INNER;
                end
                else
                begin
                    cmd.outer_next = 1'b1;
                    state_next     = S_OUTER_RD;
                end
            end
            S_INNER:
            begin
                if (status.inner_done)
                begin
                    cmd.outer_next = 1'b1;
                    state_next     = S_OUTER_RD;
                end
                else
                begin
                    cmd.inner_step = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (status.val_err)
                    begin
                        cmd.emit_err = 1'b1;
                    end
                    else if (status.val_one)
                    begin
                        cmd.emit_one = 1'b1;
                    end
                    else
                    begin
                        cmd.accept = 1'b1;
                        state_next = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP:
            begin
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (status.p_invalid)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = status.p_is_rem ? S_FINAL : S_LOOKUP;
                end
            end
            S_FINAL:
            begin
                cmd.emit_final = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: rtl/core/prime_factorization_spf_unit.sv
// Top level of the smallest-prime-factor sieve factorizer.
// After reset the unit fills its smallest-prime-factor table and holds busy high until the
// table is done: it presets every entry, then marks the multiples of each odd prime below
// the square root of the table depth. A value is taken when start is high and busy is low.
// Values 0, 1 and values not below MAX_VALUE give one word on the next cycle and leave the
// unit ready at once. Any other value keeps the unit busy while it reads the table once per
// prime factor, counted with multiplicity (at most 15 factors), through the single table
// read port. Each result word is shown for exactly one cycle with valid high, primes in
// increasing order, last high on the final word; the receiver cannot stall, so it must take
// every word.
module prime_factorization_spf_unit #(
    parameter int MAX_VALUE = pfs_pkg::DEFAULT_MAX_VALUE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pfs_pkg::DATA_W-1:0]    value,
    output logic                          valid,
    output logic [pfs_pkg::DATA_W-1:0]    prime,
    output logic [pfs_pkg::EXP_W-1:0]     exponent,
    output logic                          last,
    output logic                          error
);

    pfs_pkg::pfs_cmd_t    cmd;
    pfs_pkg::pfs_status_t status;

    // Sequence the sieve and the factor loop
    pfs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Hold the table and factor registers
    pfs_datapath #(
        .MAX_VALUE (MAX_VALUE)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .value    (value),
        .status   (status),
        .valid    (valid),
        .prime    (prime),
        .exponent (exponent),
        .last     (last),
        .error    (error)
    );

endmodule

// File: rtl/core/pfs_checker.sv
// Port-level checker for the factorizer, bound to the top level.
module pfs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [pfs_pkg::DATA_W-1:0]    value,
    input logic                          valid,
    input logic [pfs_pkg::DATA_W-1:0]    prime,
    input logic [pfs_pkg::EXP_W-1:0]     exponent,
    input logic                          last,
    input logic                          error
);

    // An error word is the single, last word with empty payload
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        valid && error |-> last && (prime == '0) && (exponent == '0))
        else $error("error word carries payload or is not last");

    // A word that is not last leaves the unit busy with the rest of the value
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |-> busy)
        else $error("unit idle while words of a value are pending");

    // A word that is not last holds a real prime with nonzero exponent
    a_mid_word: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |-> !error && (prime >= 16'd2) && (exponent != '0))
        else $error("intermediate word malformed");

    // Zero gives an error word on the next cycle
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (value == '0) |=> valid && error && last)
        else $error("zero value did not give an error word");

    // One gives a single empty word on the next cycle
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (value == 16'd1) |=> valid && !error && last && (prime == '0))
        else $error("value one did not give an empty word");

endmodule

bind prime_factorization_spf_unit pfs_checker u_pfs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .value    (value),
    .valid    (valid),
    .prime    (prime),
    .exponent (exponent),
    .last     (last),
    .error    (error)
);
